// ===== src/wms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package wms_pkg;

  localparam int WINDOW_DEPTH  = 128;
  localparam int HISTORY_DEPTH = 16;

  localparam int WIN_AW  = $clog2(WINDOW_DEPTH);
  localparam int LEN_W   = WIN_AW + 1;            // holds 0..WINDOW_DEPTH
  localparam int HIST_AW = $clog2(HISTORY_DEPTH);
  localparam int SUM_W   = 32 + LEN_W;            // exact signed window sum
  localparam int OP_W    = 64 + LEN_W;            // exact sum of squares
  localparam int ALU_W   = 36;                    // shared compare/subtract width
  localparam int STEP_W  = $clog2(OP_W + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH = 2'd0,
    REG_UPDATE_EVERY  = 2'd1,
    REG_DELAY_STEPS   = 2'd2
  } wms_reg_t;

  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } wms_op_t;

  typedef struct packed {
    logic    start;
    wms_op_t op;
  } wms_cmd_t;

endpackage
`default_nettype wire

// ===== src/windowed_mean_stddev.sv =====
// An item that triggers no update goes through the history reads (S_HRD0..S_HRD2) to S_OUT.
// An updating item makes two window passes (count = samples in the window, up to
// 128) through the sample RAM, which has one write and one read port, then
// divide, divide and square root on one shared unit, and a history write.
// One item at a time; in_stall is high after accept until the result is loaded.
// Reset (synchronous, rst_n low) clears indices, countdown and history valid bits.
`timescale 1ns / 1ps
`default_nettype none
module windowed_mean_stddev
  import wms_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic signed [31:0]    in_sample,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_updated,
  output logic signed [31:0]         out_mean,
  output logic [30:0]                out_stddev,
  output logic signed [31:0]         out_delayed_mean,
  output logic [30:0]                out_delayed_stddev
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_SUM  = 11'b00000000010,
    S_MDIV = 11'b00000000100,
    S_VAR  = 11'b00000001000,
    S_VDIV = 11'b00000010000,
    S_SQRT = 11'b00000100000,
    S_HWR  = 11'b00001000000,
    S_HRD0 = 11'b00010000000,
    S_HRD1 = 11'b00100000000,
    S_HRD2 = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]  win_len_r;
  logic [15:0] upd_every_r;
  logic [3:0]  delay_r;

  logic [WIN_AW-1:0]  wr_idx_r, wr_idx_nxt;
  logic               filled_r, filled_nxt;
  logic [15:0]        cd_r, cd_nxt;
  logic [HIST_AW-1:0] hist_idx_r, hist_idx_nxt;
  logic [HISTORY_DEPTH-1:0] hvalid_r, hvalid_nxt;

  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0] k_r, k_nxt;
  logic             v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt;
  logic             upd_r, upd_nxt;

  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [OP_W-1:0]         sumsq_r, sumsq_nxt;
  logic [31:0]             mean_r, mean_nxt;
  logic [31:0]             absd_r, absd_nxt;
  logic [63:0]             sq_r, sq_nxt;
  logic [30:0]             sd_r, sd_nxt;
  logic [62:0]             cur_r, cur_nxt, dly_r, dly_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        o_upd_r, o_upd_nxt;
  logic [62:0] o_cur_r, o_cur_nxt, o_dly_r, o_dly_nxt;

  logic [LEN_W-1:0]   eff_len, wr_inc, new_cnt;
  logic               accept, cd_zero;
  logic [HIST_AW-1:0] last_idx, dly_idx, h_raddr;
  logic [15:0]        dly_tmp;
  logic               dly_ok;

  logic [31:0]     win_rdata;
  logic            win_we;
  logic [63:0]     h_rdata;
  logic            h_we;

  wms_cmd_t        u_cmd;
  logic [OP_W-1:0] u_operand, u_result;
  logic            u_done;

  logic signed [32:0] dif;
  logic [SUM_W-1:0]   sum_mag;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r   <= 8'd100;
      upd_every_r <= 16'd1;
      delay_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH: win_len_r   <= cfg_wdata[7:0];
        REG_UPDATE_EVERY:  upd_every_r <= cfg_wdata;
        REG_DELAY_STEPS:   delay_r     <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (win_len_r == 8'd0) eff_len = LEN_W'(1);
    else if (int'(win_len_r) > WINDOW_DEPTH) eff_len = LEN_W'(WINDOW_DEPTH);
    else eff_len = LEN_W'(win_len_r);
    wr_inc = LEN_W'(wr_idx_r) + 1'b1;
  end

  assign cd_zero = (cd_r == 16'd0);

  // history read addresses
  always_comb begin
    last_idx = (hist_idx_r == '0) ? HIST_AW'(HISTORY_DEPTH - 1) : hist_idx_r - 1'b1;
    dly_ok   = (int'(delay_r) < HISTORY_DEPTH);
    if (16'(last_idx) >= 16'(delay_r)) dly_tmp = 16'(last_idx) - 16'(delay_r);
    else dly_tmp = 16'(last_idx) + 16'(HISTORY_DEPTH) - 16'(delay_r);
    dly_idx = dly_tmp[HIST_AW-1:0];
    h_raddr = (state_r == S_HRD0) ? last_idx : dly_idx;
  end

  assign dif     = {win_rdata[31], win_rdata} - {mean_r[31], mean_r};
  assign sum_mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  always_comb begin
    state_nxt    = state_r;
    wr_idx_nxt   = wr_idx_r;
    filled_nxt   = filled_r;
    cd_nxt       = cd_r;
    hist_idx_nxt = hist_idx_r;
    hvalid_nxt   = hvalid_r;
    cnt_nxt      = cnt_r;
    k_nxt        = k_r;
    v1_nxt       = 1'b0;
    v2_nxt       = 1'b0;
    v3_nxt       = 1'b0;
    upd_nxt      = upd_r;
    sum_nxt      = sum_r;
    sumsq_nxt    = sumsq_r;
    mean_nxt     = mean_r;
    absd_nxt     = absd_r;
    sq_nxt       = sq_r;
    sd_nxt       = sd_r;
    cur_nxt      = cur_r;
    dly_nxt      = dly_r;
    out_valid_nxt = out_valid_r && out_stall;
    o_upd_nxt    = o_upd_r;
    o_cur_nxt    = o_cur_r;
    o_dly_nxt    = o_dly_r;
    win_we       = 1'b0;
    h_we         = 1'b0;
    u_cmd        = '{start: 1'b0, op: OP_DIV};
    u_operand    = OP_W'(sum_mag);
    new_cnt      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          win_we = 1'b1;
          if (wr_inc >= eff_len) begin
            wr_idx_nxt = '0;
            filled_nxt = 1'b1;
            new_cnt    = eff_len;
          end else begin
            wr_idx_nxt = wr_inc[WIN_AW-1:0];
            new_cnt    = filled_r ? eff_len : wr_inc;
          end
          upd_nxt = cd_zero;
          if (cd_zero) begin
            cd_nxt    = (upd_every_r == 16'd0) ? 16'd0 : upd_every_r - 1'b1;
            cnt_nxt   = new_cnt;
            k_nxt     = '0;
            sum_nxt   = '0;
            state_nxt = S_SUM;
          end else begin
            cd_nxt    = cd_r - 1'b1;
            state_nxt = S_HRD0;
          end
        end
      end
      S_SUM: begin
        if (k_r < cnt_r) begin
          k_nxt  = k_r + 1'b1;
          v1_nxt = 1'b1;
        end
        if (v1_r) sum_nxt = sum_r + SUM_W'(signed'(win_rdata));
        if (k_r == cnt_r && !v1_r) begin
          u_cmd     = '{start: 1'b1, op: OP_DIV};
          state_nxt = S_MDIV;
        end
      end
      S_MDIV: begin
        if (u_done) begin
          mean_nxt  = sum_r[SUM_W-1] ? -u_result[31:0] : u_result[31:0];
          k_nxt     = '0;
          sumsq_nxt = '0;
          state_nxt = S_VAR;
        end
      end
      S_VAR: begin
        // read, absolute deviation, square, accumulate
        if (k_r < cnt_r) begin
          k_nxt  = k_r + 1'b1;
          v1_nxt = 1'b1;
        end
        v2_nxt = v1_r;
        v3_nxt = v2_r;
        if (v1_r) absd_nxt = dif[32] ? 32'(-dif) : dif[31:0];
        if (v2_r) sq_nxt = absd_r * absd_r;
        if (v3_r) sumsq_nxt = sumsq_r + OP_W'(sq_r);
        if (k_r == cnt_r && !v1_r && !v2_r && !v3_r) begin
          u_cmd     = '{start: 1'b1, op: OP_DIV};
          u_operand = sumsq_r;
          state_nxt = S_VDIV;
        end
      end
      S_VDIV: begin
        if (u_done) begin
          u_cmd     = '{start: 1'b1, op: OP_SQRT};
          u_operand = OP_W'(u_result[63:0]);
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (u_done) begin
          sd_nxt    = u_result[31] ? 31'h7FFF_FFFF : u_result[30:0];
          state_nxt = S_HWR;
        end
      end
      S_HWR: begin
        h_we = 1'b1;
        hvalid_nxt[hist_idx_r] = 1'b1;
        hist_idx_nxt = (hist_idx_r == HIST_AW'(HISTORY_DEPTH - 1)) ? '0
                                                                   : hist_idx_r + 1'b1;
        state_nxt = S_HRD0;
      end
      S_HRD0: state_nxt = S_HRD1;
      S_HRD1: begin
        cur_nxt   = hvalid_r[last_idx] ? h_rdata[62:0] : '0;
        state_nxt = S_HRD2;
      end
      S_HRD2: begin
        dly_nxt   = (dly_ok && hvalid_r[dly_idx]) ? h_rdata[62:0] : '0;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          o_upd_nxt     = upd_r;
          o_cur_nxt     = cur_r;
          o_dly_nxt     = dly_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_idx_r    <= '0;
      filled_r    <= 1'b0;
      cd_r        <= '0;
      hist_idx_r  <= '0;
      hvalid_r    <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_idx_r    <= wr_idx_nxt;
      filled_r    <= filled_nxt;
      cd_r        <= cd_nxt;
      hist_idx_r  <= hist_idx_nxt;
      hvalid_r    <= hvalid_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r   <= cnt_nxt;
    k_r     <= k_nxt;
    upd_r   <= upd_nxt;
    sum_r   <= sum_nxt;
    sumsq_r <= sumsq_nxt;
    mean_r  <= mean_nxt;
    absd_r  <= absd_nxt;
    sq_r    <= sq_nxt;
    sd_r    <= sd_nxt;
    cur_r   <= cur_nxt;
    dly_r   <= dly_nxt;
    o_upd_r <= o_upd_nxt;
    o_cur_r <= o_cur_nxt;
    o_dly_r <= o_dly_nxt;
  end

  wms_ram #(.WIDTH(32), .DEPTH(WINDOW_DEPTH)) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (wr_idx_r),
    .wdata (in_sample),
    .raddr (k_r[WIN_AW-1:0]),
    .rdata (win_rdata)
  );

  wms_ram #(.WIDTH(64), .DEPTH(HISTORY_DEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (hist_idx_r),
    .wdata ({1'b0, sd_r, mean_r}),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  wms_divsqrt u_divsqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (u_cmd),
    .operand (u_operand),
    .divisor (cnt_r),
    .done    (u_done),
    .result  (u_result)
  );

  assign out_valid          = out_valid_r;
  assign out_updated        = o_upd_r;
  assign out_mean           = o_cur_r[31:0];
  assign out_stddev         = o_cur_r[62:32];
  assign out_delayed_mean   = o_dly_r[31:0];
  assign out_delayed_stddev = o_dly_r[62:32];

  a_load_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result loaded outside the output step");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_SUM || state_r == S_HRD0)
    else $error("accepted item did not start processing");

  a_hist_marked: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_HWR |=> hvalid_r[$past(hist_idx_r)])
    else $error("history entry not marked valid after write");

endmodule
`default_nettype wire

// ===== src/wms_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/wms_divsqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wms_divsqrt
  import wms_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire wms_cmd_t         cmd,
  input  wire logic [OP_W-1:0]  operand,
  input  wire logic [LEN_W-1:0] divisor,
  output logic                  done,
  output logic [OP_W-1:0]       result
);

  logic              busy_r, busy_nxt;
  wms_op_t           op_r, op_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [OP_W-1:0]   acc_r, acc_nxt;
  logic [33:0]       rem_r, rem_nxt;
  logic [31:0]       root_r, root_nxt;
  logic [LEN_W-1:0]  dvs_r, dvs_nxt;
  logic              done_r, done_nxt;

  logic [ALU_W-1:0]  alu_a, alu_b;
  logic [ALU_W:0]    diff;
  logic              ge;

  // one compare/subtract shared by both operations
  always_comb begin
    if (op_r == OP_DIV) begin
      alu_a = ALU_W'({rem_r[LEN_W-1:0], acc_r[OP_W-1]});
      alu_b = ALU_W'(dvs_r);
    end else begin
      alu_a = {rem_r, acc_r[OP_W-1 -: 2]};
      alu_b = ALU_W'({root_r, 2'b01});
    end
    diff = {1'b0, alu_a} - {1'b0, alu_b};
    ge   = ~diff[ALU_W];
  end

  always_comb begin
    busy_nxt = busy_r;
    op_nxt   = op_r;
    step_nxt = step_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      op_nxt   = cmd.op;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
      root_nxt = '0;
      if (cmd.op == OP_DIV) begin
        acc_nxt  = operand;
        step_nxt = STEP_W'(OP_W);
      end else begin
        acc_nxt  = {operand[63:0], {(OP_W-64){1'b0}}};
        step_nxt = STEP_W'(32);
      end
    end else if (busy_r) begin
      if (op_r == OP_DIV) begin
        rem_nxt = ge ? 34'(diff[LEN_W-1:0]) : 34'(alu_a[LEN_W-1:0]);
        acc_nxt = {acc_r[OP_W-2:0], ge};
      end else begin
        rem_nxt  = ge ? diff[33:0] : alu_a[33:0];
        root_nxt = {root_r[30:0], ge};
        acc_nxt  = {acc_r[OP_W-3:0], 2'b00};
      end
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
      op_r   <= OP_DIV;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
      op_r   <= op_nxt;
    end
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign done   = done_r;
  assign result = (op_r == OP_DIV) ? acc_r : OP_W'(root_r);

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divsqrt done without a running operation");

  a_step_live: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> step_r != '0)
    else $error("divsqrt busy with zero steps left");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !done_nxt |=> busy_r || done_r)
    else $error("divsqrt dropped an operation");

endmodule
`default_nettype wire
